>>> hw/rtl/signed_binary_to_decimal_ascii_unit_macros.svh
// Assertion macros used by the checker of the decimal ASCII unit.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SBDA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SBDA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sbda_pkg.sv
// Shared types, constants and helpers of the decimal ASCII unit.
package sbda_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int CHAR_W         = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

    // decimal digits needed for 2^(bits-1), the largest magnitude
    function automatic int bcd_digits(input int bits);
        return ((bits - 1) * 30103) / 100000 + 1;
    endfunction

    localparam int DIGITS_DEF = bcd_digits(VALUE_BITS_DEF);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // command from the sequencer to the character emitter
    typedef struct packed {
        logic start;
        logic negative;
    } t_emit_cmd;

endpackage

>>> hw/rtl/signed_binary_to_decimal_ascii_unit.sv
// Signed binary to decimal ASCII unit: top level with the transaction sequencer.
// Takes one two's complement value of VALUE_BITS bits per input transaction and sends its
// decimal text as ASCII characters, most significant digit first, '-' first for a negative
// value, no leading zeros, zero as a single '0', o_last high on the final character. The
// most negative value prints as its full unsigned magnitude. One value is handled at a
// time: o_stall stays high from the accepting edge until the last character is taken.
// The magnitude passes first through the bit-serial double-dabble shift register, then
// the character emitter walks its DIGITS BCD digits (DIGITS = 10 at 32 bits) and holds
// its character while the output is stalled.
module signed_binary_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [VALUE_BITS-1:0]       i_signed_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sbda_pkg::CHAR_W-1:0] o_character,
    output logic                        o_last
);
    import sbda_pkg::*;

    localparam int DIGITS = bcd_digits(VALUE_BITS);

    t_state                r_state, n_state;
    logic                  r_neg, n_neg;
    logic                  w_accept;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_conv_done;
    logic [DIGITS*4-1:0]   w_bcd;
    t_emit_cmd             w_cmd;
    logic                  w_emit_done;

    assign w_accept = i_valid && (r_state == ST_IDLE);
    // two's complement magnitude; the most negative value lands on 2^(VALUE_BITS-1)
    assign w_mag    = i_signed_value[VALUE_BITS-1] ? (~i_signed_value + VALUE_BITS'(1))
                                                   : i_signed_value;

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        w_cmd.start = 1'b0;
        w_cmd.negative = r_neg;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_signed_value[VALUE_BITS-1];
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (w_conv_done) begin
                    w_cmd.start = 1'b1;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
    end

    assign o_stall = (r_state != ST_IDLE);

    sbda_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_mag   (w_mag),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    sbda_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_bcd       (w_bcd),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last),
        .o_done      (w_emit_done)
    );

endmodule

>>> hw/rtl/sbda_dabble.sv
// Bit-serial double-dabble: shifts the magnitude into a BCD register one bit per cycle.
module sbda_dabble #(
    parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF,
    parameter int DIGITS     = sbda_pkg::DIGITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [VALUE_BITS-1:0]   i_mag,
    output logic                    o_done,
    output logic [DIGITS*4-1:0]     o_bcd
);
    import sbda_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [DIGITS*4-1:0]   r_bcd, n_bcd;
    logic [DIGITS*4-1:0]   w_corr;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [3:0]            v_dig;

    // add-3 on every digit of five or more before the shift
    always_comb begin
        w_corr = '0;
        v_dig  = '0;
        for (int i = 0; i < DIGITS; i++) begin
            v_dig = r_bcd[i*4 +: 4];
            w_corr[i*4 +: 4] = (v_dig >= 4'd5) ? v_dig + 4'd3 : v_dig;
        end
    end

    always_comb begin
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_count = r_count;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_bin   = i_mag;
            n_bcd   = '0;
            n_count = CNT_W'(VALUE_BITS);
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_bcd   = {w_corr[DIGITS*4-2:0], r_bin[VALUE_BITS-1]};
            n_bin   = {r_bin[VALUE_BITS-2:0], 1'b0};
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

>>> hw/rtl/sbda_emit.sv
// Character emitter: BCD digits to a registered output, one per unstalled cycle.
module sbda_emit #(
    parameter int DIGITS = sbda_pkg::DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbda_pkg::t_emit_cmd         i_cmd,
    input  logic [DIGITS*4-1:0]         i_bcd,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [sbda_pkg::CHAR_W-1:0] o_character,
    output logic                        o_last,
    output logic                        o_done
);
    import sbda_pkg::*;

    localparam int LEFT_W = $clog2(DIGITS + 1);

    logic [DIGITS*4-1:0] r_bcd, n_bcd;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_lead, n_lead;
    logic                r_sign, n_sign;
    logic                r_valid, n_valid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;
    logic [3:0]          w_dig;
    logic                w_free;

    assign w_dig  = r_bcd[DIGITS*4-1 -: 4];
    assign w_free = !r_valid || !i_stall;

    always_comb begin
        n_bcd   = r_bcd;
        n_left  = r_left;
        n_lead  = r_lead;
        n_sign  = r_sign;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        if (i_cmd.start) begin
            n_bcd  = i_bcd;
            n_left = LEFT_W'(DIGITS);
            n_lead = 1'b1;
            n_sign = i_cmd.negative;
        end else if (w_free) begin
            n_valid = 1'b0;
            if (r_sign) begin
                n_sign  = 1'b0;
                n_valid = 1'b1;
                n_char  = CHAR_MINUS;
                n_last  = 1'b0;
            end else if (r_left != '0) begin
                n_bcd  = {r_bcd[DIGITS*4-5:0], 4'd0};
                n_left = r_left - LEFT_W'(1);
                // leading zeros are dropped, but the units digit always goes out
                if (!(r_lead && w_dig == 4'd0 && r_left != LEFT_W'(1))) begin
                    n_valid = 1'b1;
                    n_char  = CHAR_ZERO | {4'd0, w_dig};
                    n_last  = (r_left == LEFT_W'(1));
                    n_lead  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sign  <= 1'b0;
            r_left  <= '0;
            r_lead  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sign  <= n_sign;
            r_left  <= n_left;
            r_lead  <= n_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_done      = r_valid && !i_stall && r_last;

endmodule

>>> hw/rtl/sbda_checker.sv
// Port-level checker for the decimal ASCII unit, bound to the top level.
`include "signed_binary_to_decimal_ascii_unit_macros.svh"

module sbda_checker #(
    parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [VALUE_BITS-1:0]       i_signed_value,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [sbda_pkg::CHAR_W-1:0] o_character,
    input logic                        o_last
);
    import sbda_pkg::*;

    // a stalled character holds
    `SBDA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_character) && $stable(o_last), "stalled character changed")

    // only '-' or a digit ever goes out
    `SBDA_ASSERT_IMP(a_char_code, i_clk, i_rst_n, o_valid, o_character == CHAR_MINUS || (o_character >= CHAR_ZERO && o_character <= CHAR_NINE), "illegal character code")

    // a sign is never marked as the last character
    `SBDA_ASSERT_IMP(a_sign_not_last, i_clk, i_rst_n, o_valid && o_character == CHAR_MINUS, !o_last, "sign marked as last")

    // no new value is taken while characters of the current one are pending
    `SBDA_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_valid, o_stall, "input open with output pending")

    // an accepted value closes the input on the next cycle
    `SBDA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input open after accept")

endmodule

bind signed_binary_to_decimal_ascii_unit sbda_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_sbda_checker (.*);

>>> test/signed_binary_to_decimal_ascii_unit_tb.sv
// Self-checking testbench for the signed binary to decimal ASCII unit.
module signed_binary_to_decimal_ascii_unit_tb;
    import sbda_pkg::*;

    localparam int VALUE_BITS  = 32;
    localparam int ITEM_CYCLES = 50;
    localparam logic [VALUE_BITS-1:0] DECIMAL_BASE = 10;

    typedef struct packed {
        logic [VALUE_BITS-1:0] source;
        logic [CHAR_W-1:0]     code;
        logic                  last;
    } t_text_char;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [VALUE_BITS-1:0] i_signed_value = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [CHAR_W-1:0]     o_character;
    logic                  o_last;

    t_text_char expected_text[$];
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         values_sent = 0;
    int         negatives_sent = 0;
    int         chars_checked = 0;
    int         mismatch_count = 0;

    signed_binary_to_decimal_ascii_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_signed_value(i_signed_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_character   (o_character),
        .o_last        (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4 * 600000);
        $display("timeout: %0d characters still outstanding", expected_text.size());
        $display("signed_binary_to_decimal_ascii_unit_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // decimal text of the value: optional '-', then digits MSD first, last on the final one
    function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] magnitude;
        logic [CHAR_W-1:0]     digit;
        logic [CHAR_W-1:0]     digits[$];
        t_text_char            entry;
        magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        do begin
            digit = CHAR_W'(magnitude % DECIMAL_BASE);
            digits.push_front(CHAR_ZERO + digit);
            magnitude = magnitude / DECIMAL_BASE;
        end while (magnitude != 0);
        entry.source = value;
        if (value[VALUE_BITS-1]) begin
            entry.code = CHAR_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
        end
        foreach (digits[k]) begin
            entry.code = digits[k];
            entry.last = (k == digits.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    // valid stays up across back-to-back transactions; it drops only when idling
    task automatic send_value(input logic [VALUE_BITS-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_signed_value <= $urandom;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_signed_value <= value;
        do @(posedge i_clk); while (o_stall);
        queue_decimal_text(value);
        values_sent++;
        if (value[VALUE_BITS-1])
            negatives_sent++;
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_text
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h", o_character));
            end else begin
                want = expected_text.pop_front();
                if (o_character !== want.code)
                    report_mismatch($sformatf("value %0d: character 0x%02h, expected 0x%02h",
                        $signed(want.source), o_character, want.code));
                if (o_last !== want.last)
                    report_mismatch($sformatf("value %0d: last %b, expected %b",
                        $signed(want.source), o_last, want.last));
                chars_checked++;
            end
        end
    end

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] value;
        // shifting spreads the digit count evenly instead of favoring ten digits
        if ($urandom_range(3) == 0)
            value = $urandom;
        else
            value = $urandom >> $urandom_range(VALUE_BITS - 1);
        if ($urandom_range(1))
            value = ~value + 1'b1;
        return value;
    endfunction

    task automatic test_zero_and_sign();
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        send_value(32'sd7);
        send_value(-32'sd7);
    endtask

    task automatic test_extremes();
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h8000_0001);
        send_value(32'h7FFF_FFFE);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
    endtask

    task automatic test_decade_boundaries();
        send_value(32'sd9);
        send_value(32'sd10);
        send_value(-32'sd99);
        send_value(-32'sd100);
        send_value(32'sd999999999);
        send_value(32'sd1000000000);
        send_value(32'sd1234567890);
        send_value(-32'sd987654321);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int hold_pct);
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        repeat (count) send_value(random_value());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_and_sign();
        test_extremes();
        test_decade_boundaries();
        test_random_traffic(108, 0, 0);
        test_random_traffic(108, 85, 0);
        test_random_traffic(108, 0, 85);
        test_random_traffic(108, 13, 13);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (expected_text.size() == 0);
        repeat (2 * ITEM_CYCLES) @(posedge i_clk);

        $display("converted %0d values (%0d negative), checked %0d characters",
            values_sent, negatives_sent, chars_checked);
        $display("idling phases: none, sender 85%%, receiver 85%%, both 13%%; %0d mismatches",
            mismatch_count);
        if (mismatch_count == 0)
            $display("signed_binary_to_decimal_ascii_unit_tb: PASS");
        else
            $display("signed_binary_to_decimal_ascii_unit_tb: FAIL");
        $finish;
    end

endmodule
